// ----- rtl/imhq_pkg.sv -----
// Shared constants for the indexed min-heap queue unit.
// Holds operation and status codes, sizes and the present command type; no dependencies.
package imhq_pkg;
   localparam logic [1:0] MODE_INSERT  = 2'd0;
   localparam logic [1:0] MODE_UPDATE  = 2'd1;
   localparam logic [1:0] MODE_EXTRACT = 2'd2;

   localparam logic [2:0] STATUS_OK      = 3'd0;
   localparam logic [2:0] STATUS_EMPTY   = 3'd1;
   localparam logic [2:0] STATUS_FULL    = 3'd2;
   localparam logic [2:0] STATUS_ABSENT  = 3'd3;
   localparam logic [2:0] STATUS_PRESENT = 3'd4;

   localparam int KEY_BITS = 8;
   localparam int NUM_KEYS = 256;
   localparam int REQ_BYTES_BITS = 48;
   localparam int RSP_BYTES_BITS = 96;

   typedef struct packed {
      logic                set;
      logic                clear;
      logic [KEY_BITS-1:0] key;
   } present_cmd_type;
endpackage

// ----- rtl/indexed_min_heap_queue_unit.sv -----
// Indexed binary min-heap queue: top level with the sift sequencer.
// Depends on imhq_pkg, imhq_heap_mem and imhq_pos_mem.
//
// Usage: each transfer on the req_ channel is one command (insert,
// update priority, extract minimum) and yields exactly one transfer on
// the rsp_ channel with status, the extracted entry, the new minimum and
// the entry count. One command is worked on at a time. A command walks
// the heap one level per step: a sift-up step reads the parent, then
// compares and moves; a sift-down step reads the left child, the right
// child if there is one, then compares and moves. This order follows from
// the single read port of the heap memory: reads come before the move.
// The result sits in an output register; a new command is accepted while
// it waits, and the block holds its next result until the receiver takes
// the previous one. Reset empties the heap and marks every key absent
// at once; commands are accepted in the cycle after reset is released.
module indexed_min_heap_queue_unit
   import imhq_pkg::*;
#(
   parameter int CAPACITY      = 256,
   parameter int PRIORITY_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // mode[1:0], key[9:2], priority_req[41:10], zero fill
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[2:0], taken_valid[3], taken_key[11:4], taken_priority[43:12],
   // min_valid[44], min_key[52:45], min_priority[84:53], count[93:85], zero fill
   output logic [95:0] rsp_tdata
);
   localparam int LIMIT = (CAPACITY < NUM_KEYS) ? CAPACITY : NUM_KEYS;
   localparam int IW    = $clog2(LIMIT);
   localparam int CW    = $clog2(LIMIT + 1);
   localparam int PW    = (PRIORITY_BITS < 32) ? PRIORITY_BITS : 32;
   localparam int EW    = KEY_BITS + PW;
   localparam int XW    = IW + 2;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECIDE = 4'd1;
   localparam logic [3:0] S_UPD    = 4'd2;
   localparam logic [3:0] S_EX0    = 4'd3;
   localparam logic [3:0] S_EX1    = 4'd4;
   localparam logic [3:0] S_UP     = 4'd5;
   localparam logic [3:0] S_UP_CMP = 4'd6;
   localparam logic [3:0] S_DOWN   = 4'd7;
   localparam logic [3:0] S_DN_L   = 4'd8;
   localparam logic [3:0] S_DN_R   = 4'd9;
   localparam logic [3:0] S_DN_CMP = 4'd10;
   localparam logic [3:0] S_FIN    = 4'd11;
   localparam logic [3:0] S_TOP    = 4'd12;

   logic [3:0]          state_ff, state_in;
   logic [1:0]          mode_ff, mode_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [PW-1:0]       pri_ff, pri_in;
   logic [2:0]          status_ff, status_in;
   logic                tv_ff, tv_in;
   logic [KEY_BITS-1:0] tk_ff, tk_in;
   logic [PW-1:0]       tp_ff, tp_in;
   logic [KEY_BITS-1:0] cur_key_ff, cur_key_in;
   logic [PW-1:0]       cur_pri_ff, cur_pri_in;
   logic [IW-1:0]       cur_pos_ff, cur_pos_in;
   logic [KEY_BITS-1:0] ch_key_ff, ch_key_in;
   logic [PW-1:0]       ch_pri_ff, ch_pri_in;
   logic [IW-1:0]       ch_pos_ff, ch_pos_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [95:0]         rsp_data_ff, rsp_data_in;

   logic                h_wr_en;
   logic [IW-1:0]       h_wr_addr, h_rd_addr;
   logic [EW-1:0]       h_wr_data, h_rd_data;
   logic [KEY_BITS-1:0] rd_key;
   logic [PW-1:0]       rd_pri;
   logic                p_wr_en;
   logic [KEY_BITS-1:0] p_wr_key, p_rd_key;
   logic [IW-1:0]       p_wr_pos, p_rd_pos;
   present_cmd_type     pres_cmd;
   logic                key_present;

   logic [KEY_BITS-1:0] req_key;
   logic [XW-1:0]       left_idx, right_idx, count_x;
   logic [IW-1:0]       parent_idx;
   logic                out_free;

   assign req_key    = req_tdata[9:2];
   assign rd_key     = h_rd_data[EW-1 -: KEY_BITS];
   assign rd_pri     = h_rd_data[PW-1:0];
   assign left_idx   = XW'({cur_pos_ff, 1'b1});
   assign right_idx  = left_idx + XW'(1);
   assign count_x    = XW'(count_ff);
   assign parent_idx = IW'((cur_pos_ff - IW'(1)) >> 1);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   imhq_heap_mem #(.DEPTH(LIMIT), .WIDTH(EW)) u_heap (
      .clock   (clock),
      .wr_en   (h_wr_en),
      .wr_addr (h_wr_addr),
      .wr_data (h_wr_data),
      .rd_addr (h_rd_addr),
      .rd_data (h_rd_data)
   );

   imhq_pos_mem #(.POS_BITS(IW)) u_pos (
      .clock         (clock),
      .reset         (reset),
      .wr_en         (p_wr_en),
      .wr_key        (p_wr_key),
      .wr_pos        (p_wr_pos),
      .rd_key        (p_rd_key),
      .rd_pos        (p_rd_pos),
      .present_cmd   (pres_cmd),
      .probe_key     (key_ff),
      .probe_present (key_present)
   );

   assign p_rd_key = (state_ff == S_IDLE) ? req_key : key_ff;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      key_in       = key_ff;
      pri_in       = pri_ff;
      status_in    = status_ff;
      tv_in        = tv_ff;
      tk_in        = tk_ff;
      tp_in        = tp_ff;
      cur_key_in   = cur_key_ff;
      cur_pri_in   = cur_pri_ff;
      cur_pos_in   = cur_pos_ff;
      ch_key_in    = ch_key_ff;
      ch_pri_in    = ch_pri_ff;
      ch_pos_in    = ch_pos_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      h_wr_en      = 1'b0;
      h_wr_addr    = cur_pos_ff;
      h_wr_data    = {cur_key_ff, cur_pri_ff};
      h_rd_addr    = '0;
      p_wr_en      = 1'b0;
      p_wr_key     = cur_key_ff;
      p_wr_pos     = cur_pos_ff;
      pres_cmd     = '{set: 1'b0, clear: 1'b0, key: key_ff};
      req_tready   = (state_ff == S_IDLE);

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               mode_in   = req_tdata[1:0];
               key_in    = req_key;
               pri_in    = PW'(req_tdata[41:10]);
               status_in = STATUS_OK;
               tv_in     = 1'b0;
               tk_in     = '0;
               tp_in     = '0;
               state_in  = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cur_key_in = key_ff;
            cur_pri_in = pri_ff;
            priority case (mode_ff)
               MODE_INSERT: begin
                  if (32'(count_ff) >= 32'(CAPACITY)) begin
                     status_in = STATUS_FULL;
                     state_in  = S_FIN;
                  end else if (key_present) begin
                     status_in = STATUS_PRESENT;
                     state_in  = S_FIN;
                  end else begin
                     cur_pos_in   = IW'(count_ff);
                     count_in     = count_ff + CW'(1);
                     pres_cmd.set = 1'b1;
                     state_in     = S_UP;
                  end
               end
               MODE_UPDATE: begin
                  if (!key_present) begin
                     status_in = STATUS_ABSENT;
                     state_in  = S_FIN;
                  end else begin
                     cur_pos_in = p_rd_pos;
                     h_rd_addr  = p_rd_pos;
                     state_in   = S_UPD;
                  end
               end
               MODE_EXTRACT: begin
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                     state_in  = S_FIN;
                  end else begin
                     h_rd_addr = '0;
                     state_in  = S_EX0;
                  end
               end
               default: begin
                  state_in = S_FIN;
               end
            endcase
         end
         S_UPD: begin
            state_in = (pri_ff > rd_pri) ? S_DOWN : S_UP;
         end
         S_EX0: begin
            tv_in          = 1'b1;
            tk_in          = rd_key;
            tp_in          = rd_pri;
            pres_cmd.clear = 1'b1;
            pres_cmd.key   = rd_key;
            h_rd_addr      = IW'(count_ff - CW'(1));
            count_in       = count_ff - CW'(1);
            state_in       = S_EX1;
         end
         S_EX1: begin
            cur_key_in = rd_key;
            cur_pri_in = rd_pri;
            cur_pos_in = '0;
            state_in   = (count_ff == '0) ? S_FIN : S_DOWN;
         end
         S_UP: begin
            if (cur_pos_ff == '0) begin
               h_wr_en  = 1'b1;
               p_wr_en  = 1'b1;
               state_in = S_FIN;
            end else begin
               h_rd_addr = parent_idx;
               state_in  = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            h_wr_en = 1'b1;
            p_wr_en = 1'b1;
            if (rd_pri > cur_pri_ff) begin
               h_wr_data  = h_rd_data;
               p_wr_key   = rd_key;
               cur_pos_in = parent_idx;
               state_in   = S_UP;
            end else begin
               state_in = S_FIN;
            end
         end
         S_DOWN: begin
            if (left_idx >= count_x) begin
               h_wr_en  = 1'b1;
               p_wr_en  = 1'b1;
               state_in = S_FIN;
            end else begin
               h_rd_addr = IW'(left_idx);
               state_in  = S_DN_L;
            end
         end
         S_DN_L: begin
            ch_key_in = rd_key;
            ch_pri_in = rd_pri;
            ch_pos_in = IW'(left_idx);
            if (right_idx < count_x) begin
               h_rd_addr = IW'(right_idx);
               state_in  = S_DN_R;
            end else begin
               state_in = S_DN_CMP;
            end
         end
         S_DN_R: begin
            if (!(ch_pri_ff < rd_pri)) begin
               ch_key_in = rd_key;
               ch_pri_in = rd_pri;
               ch_pos_in = ch_pos_ff + IW'(1);
            end
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            h_wr_en = 1'b1;
            p_wr_en = 1'b1;
            if (ch_pri_ff < cur_pri_ff) begin
               h_wr_data  = {ch_key_ff, ch_pri_ff};
               p_wr_key   = ch_key_ff;
               cur_pos_in = ch_pos_ff;
               state_in   = S_DOWN;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            state_in = S_TOP;
         end
         S_TOP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in[2:0]   = status_ff;
               rsp_data_in[3]     = tv_ff;
               rsp_data_in[11:4]  = tk_ff;
               rsp_data_in[43:12] = 32'(tp_ff);
               rsp_data_in[93:85] = 9'(count_ff);
               if (count_ff != '0) begin
                  rsp_data_in[44]    = 1'b1;
                  rsp_data_in[52:45] = rd_key;
                  rsp_data_in[84:53] = 32'(rd_pri);
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      key_ff      <= key_in;
      pri_ff      <= pri_in;
      status_ff   <= status_in;
      tv_ff       <= tv_in;
      tk_ff       <= tk_in;
      tp_ff       <= tp_in;
      cur_key_ff  <= cur_key_in;
      cur_pri_ff  <= cur_pri_in;
      cur_pos_ff  <= cur_pos_in;
      ch_key_ff   <= ch_key_in;
      ch_pri_ff   <= ch_pri_in;
      ch_pos_ff   <= ch_pos_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
endmodule

// ----- rtl/imhq_heap_mem.sv -----
// Heap slot memory: one write port, one registered read port.
// Uses no package items.
module imhq_heap_mem #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 40
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/imhq_pos_mem.sv -----
// Key-to-position memory with a present flag per key.
// Depends on imhq_pkg for key sizes and the present command type.
module imhq_pos_mem
   import imhq_pkg::*;
#(
   parameter int POS_BITS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  logic [KEY_BITS-1:0] wr_key,
   input  logic [POS_BITS-1:0] wr_pos,
   input  logic [KEY_BITS-1:0] rd_key,
   output logic [POS_BITS-1:0] rd_pos,
   input  present_cmd_type     present_cmd,
   input  logic [KEY_BITS-1:0] probe_key,
   output logic                probe_present
);
   logic [POS_BITS-1:0] mem_ff [NUM_KEYS];
   logic [POS_BITS-1:0] rd_pos_ff;
   logic [NUM_KEYS-1:0] present_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_key] <= wr_pos;
      end
      rd_pos_ff <= mem_ff[rd_key];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
      end else if (present_cmd.set) begin
         present_ff[present_cmd.key] <= 1'b1;
      end else if (present_cmd.clear) begin
         present_ff[present_cmd.key] <= 1'b0;
      end
   end

   assign rd_pos        = rd_pos_ff;
   assign probe_present = present_ff[probe_key];
endmodule

// ----- dv/indexed_min_heap_queue_unit_checker.sv -----
// Checker for the indexed min-heap queue unit: tracks a heap of its own from observed
// command transfers and compares every response transfer field by field. Depends on imhq_pkg.
module indexed_min_heap_queue_unit_checker
   import imhq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [95:0] rsp_tdata,
   output int          error_count,
   output int          pending_count,
   output int          extract_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 256;

   typedef struct packed {
      logic [8:0]  count;
      logic [31:0] min_priority;
      logic [7:0]  min_key;
      logic        min_valid;
      logic [31:0] taken_priority;
      logic [7:0]  taken_key;
      logic        taken_valid;
      logic [2:0]  status;
   } heap_result_type;

   logic [7:0]  slot_key [DEPTH];
   logic [31:0] slot_pri [DEPTH];
   int          key_slot [NUM_KEYS];
   bit          key_held [NUM_KEYS];
   int          held;
   heap_result_type expected_results[$];

   function automatic void swap_slots(int a, int b);
      logic [7:0]  k;
      logic [31:0] p;
      k = slot_key[a]; p = slot_pri[a];
      slot_key[a] = slot_key[b]; slot_pri[a] = slot_pri[b];
      slot_key[b] = k; slot_pri[b] = p;
      key_slot[slot_key[a]] = a;
      key_slot[slot_key[b]] = b;
   endfunction

   function automatic void bubble_up(int i);
      int p;
      while (i > 0) begin
         p = (i - 1) / 2;
         if (!(slot_pri[p] > slot_pri[i])) break;
         swap_slots(i, p);
         i = p;
      end
   endfunction

   function automatic void bubble_down(int i);
      int l, c;
      forever begin
         l = 2 * i + 1;
         if (l >= held) return;
         if (l + 1 >= held || slot_pri[l] < slot_pri[l + 1]) c = l;
         else c = l + 1;
         if (!(slot_pri[c] < slot_pri[i])) return;
         swap_slots(i, c);
         i = c;
      end
   endfunction

   function automatic heap_result_type apply_command(logic [47:0] d);
      heap_result_type r;
      logic [1:0]  mode;
      logic [7:0]  key;
      logic [31:0] pri, old;
      int pos;
      mode = d[1:0]; key = d[9:2]; pri = d[41:10];
      r = '0;
      r.status = STATUS_OK;
      case (mode)
         MODE_INSERT: begin
            if (held >= DEPTH) r.status = STATUS_FULL;
            else if (key_held[key]) r.status = STATUS_PRESENT;
            else begin
               slot_key[held] = key; slot_pri[held] = pri;
               key_slot[key] = held; key_held[key] = 1;
               held++;
               bubble_up(held - 1);
            end
         end
         MODE_UPDATE: begin
            if (!key_held[key]) r.status = STATUS_ABSENT;
            else begin
               pos = key_slot[key];
               old = slot_pri[pos];
               slot_pri[pos] = pri;
               if (pri > old) bubble_down(pos);
               else bubble_up(pos);
            end
         end
         MODE_EXTRACT: begin
            if (held == 0) r.status = STATUS_EMPTY;
            else begin
               r.taken_valid = 1;
               r.taken_key = slot_key[0];
               r.taken_priority = slot_pri[0];
               swap_slots(0, held - 1);
               key_held[slot_key[held - 1]] = 0;
               held--;
               bubble_down(0);
            end
         end
         default: ;
      endcase
      if (held > 0) begin
         r.min_valid = 1; r.min_key = slot_key[0]; r.min_priority = slot_pri[0];
      end
      r.count = held[8:0];
      return r;
   endfunction

   heap_result_type got, want;

   always @(posedge clock) begin
      if (reset) begin
         held = 0;
         foreach (key_held[k]) key_held[k] = 0;
         expected_results.delete();
         error_count <= 0;
         extract_count <= 0;
      end else begin
         if (req_tvalid && req_tready) expected_results.push_back(apply_command(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[93:0];
            if (expected_results.size() == 0) begin
               if (error_count < 10) $display("ERROR: unexpected response %h", got);
               error_count <= error_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (got.taken_valid) extract_count <= extract_count + 1;
               if (got !== want || rsp_tdata[95:94] !== 2'b00) begin
                  if (error_count < 10) begin
                     $display("ERROR: response mismatch: expected st=%0d tv=%0d tk=%0d tp=%h %s",
                        want.status, want.taken_valid, want.taken_key, want.taken_priority,
                        $sformatf("mv=%0d mk=%0d mp=%h n=%0d", want.min_valid, want.min_key,
                                  want.min_priority, want.count));
                     $display("       got st=%0d tv=%0d tk=%0d tp=%h mv=%0d mk=%0d mp=%h n=%0d",
                        got.status, got.taken_valid, got.taken_key, got.taken_priority,
                        got.min_valid, got.min_key, got.min_priority, got.count);
                  end
                  error_count <= error_count + 1;
               end
            end
         end
      end
      pending_count <= expected_results.size();
   end
endmodule

// ----- dv/indexed_min_heap_queue_unit_test.sv -----
// Testbench top for the indexed min-heap queue unit: drives commands with random gaps
// and stalls, and reports the verdict. Depends on imhq_pkg and the checker module.
module indexed_min_heap_queue_unit_test
   import imhq_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [95:0] rsp_tdata;
   int          error_count, pending_count, extract_count;
   int          command_count;
   bit          quiet;

   indexed_min_heap_queue_unit dut (.*);
   indexed_min_heap_queue_unit_checker checker_inst (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Verification failed");
      $finish;
   end

   initial begin
      int stall;
      rsp_tready = 0;
      stall = 0;
      forever begin
         @(posedge clock);
         if (quiet) rsp_tready <= 1;
         else if (stall > 0) begin
            stall--;
            rsp_tready <= 0;
         end else if ($urandom_range(0, 5) == 0) begin
            stall = $urandom_range(0, 3);
            rsp_tready <= 0;
         end else rsp_tready <= 1;
      end
   end

   task automatic send_command(logic [1:0] mode, logic [7:0] key, logic [31:0] pri);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {6'b0, pri, key, mode};
      do @(posedge clock); while (!req_tready);
      command_count++;
   endtask

   function automatic logic [31:0] pick_priority();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 15);
         1: return 32'hFFFF_FFF0 | $urandom_range(0, 15);
         default: return $urandom();
      endcase
   endfunction

   initial begin
      logic [1:0] mode;
      int         fill_target;
      quiet = 0;
      command_count = 0;
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_command(MODE_EXTRACT, 8'd0, 32'd0);
      send_command(MODE_UPDATE, 8'd5, 32'd1);
      send_command(MODE_INSERT, 8'd0, 32'hFFFF_FFFF);
      send_command(MODE_INSERT, 8'd255, 32'd0);
      send_command(MODE_INSERT, 8'd255, 32'd7);
      send_command(MODE_INSERT, 8'd170, 32'd7);
      send_command(MODE_INSERT, 8'd85, 32'd7);
      send_command(MODE_UPDATE, 8'd255, 32'hFFFF_FFFF);
      send_command(MODE_UPDATE, 8'd0, 32'd0);
      send_command(MODE_UPDATE, 8'd170, 32'd7);
      send_command(2'd3, 8'hFF, 32'hFFFF_FFFF);
      repeat (6) send_command(MODE_EXTRACT, 8'd0, 32'd0);

      // Fill completely, probe the full case, update random keys, then drain.
      for (int k = 0; k < NUM_KEYS; k++) send_command(MODE_INSERT, k[7:0], pick_priority());
      send_command(MODE_INSERT, 8'd3, 32'd0);
      for (int k = 0; k < 40; k++) send_command(MODE_UPDATE, 8'($urandom()), pick_priority());
      repeat (257) send_command(MODE_EXTRACT, 8'd0, 32'd0);

      for (int n = 0; n < 480; n++) begin
         if (n == 400) quiet = 1;
         fill_target = (n / 150) % 2;
         case ($urandom_range(0, 9))
            0, 1, 2, 3: mode = fill_target ? MODE_INSERT : MODE_EXTRACT;
            4, 5, 6: mode = MODE_UPDATE;
            7: mode = MODE_INSERT;
            8: mode = MODE_EXTRACT;
            default: mode = 2'($urandom_range(0, 3));
         endcase
         send_command(mode,
                      8'($urandom_range(0, 63) + ($urandom_range(0, 7) == 0 ? 192 : 0)),
                      pick_priority());
      end
      req_tvalid <= 0;

      @(posedge clock);
      while (pending_count != 0 || rsp_tvalid) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("Sent %0d commands; %0d extractions observed,", command_count, extract_count);
      $display("covering empty, full, present-key and absent-key cases.");
      if (error_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end
endmodule
